// ===== design/deq_pkg.sv =====
// deq_pkg: shared types and codes for the double-ended queue core
// beat structs for the command and result channels, operation and status codes
// no dependencies
package deq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [31:0] popped;
    logic [1:0]  status;
    logic [31:0] front_word;
    logic [31:0] back_word;
    logic [6:0]  occupancy;
  } out_t;

endpackage

// ===== design/deq_ram.sv =====
// deq_ram: ring store for the queue words, one write port and one read port
// read data is registered; no package dependencies
module deq_ram #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/double_ended_queue_core.sv =====
// double_ended_queue_core: bounded deque held in a ring store with cached end words
// depends on deq_pkg and deq_ram
//
//   channel | ports                      | handshake
//   --------+----------------------------+------------------------------
//   command | start, busy, in_beat       | taken when start & !busy
//   result  | out_valid, out_beat        | one-cycle strobe, no back-pressure
//
// pushes, failed ops and emptying pops: result strobed the cycle after the beat
// pops that leave words behind: the new end word comes from the registered
// ring store read port, then the result is strobed; busy is high during that read
// synchronous active-low reset empties the queue; store contents are not cleared
// the result side cannot stall
module double_ended_queue_core #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  deq_pkg::in_t   in_beat,
  output logic           out_valid,
  output deq_pkg::out_t  out_beat
);

  import deq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      front_idx_r, front_idx_nxt;
  logic [IDX_W-1:0]      back_idx_r, back_idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] front_word_r, front_word_nxt;
  logic [DATA_WIDTH-1:0] back_word_r, back_word_nxt;
  logic [DATA_WIDTH-1:0] pend_pop_r, pend_pop_nxt;
  logic                  pend_front_r, pend_front_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_r, out_nxt;

  logic                  accept;
  logic [EXT_W-1:0]      value_ext;
  logic [DATA_WIDTH-1:0] word_in;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : IDX_W'(i - 1'b1);
  endfunction

  function automatic logic [31:0] to_field(input logic [DATA_WIDTH-1:0] w);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(w);
    return ext[31:0];
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state_r == S_READ);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;
  assign value_ext = EXT_W'(in_beat.value);
  assign word_in   = value_ext[DATA_WIDTH-1:0];

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (word_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    front_idx_nxt  = front_idx_r;
    back_idx_nxt   = back_idx_r;
    count_nxt      = count_r;
    front_word_nxt = front_word_r;
    back_word_nxt  = back_word_r;
    pend_pop_nxt   = pend_pop_r;
    pend_front_nxt = pend_front_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.popped = '0;
          out_nxt.status = ST_DONE;
          out_valid_nxt  = 1'b1;
          unique case (in_beat.func) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (count_r == CNT_FULL) begin
                out_nxt.status = ST_FULL;
              end else begin
                count_nxt = CNT_W'(count_r + 1'b1);
                wr_en     = 1'b1;
                if (in_beat.func == OP_PUSH_FRONT) begin
                  front_idx_nxt  = ring_dec(front_idx_r);
                  wr_addr        = front_idx_nxt;
                  front_word_nxt = word_in;
                  if (count_r == '0) begin
                    back_word_nxt = word_in;
                  end
                end else begin
                  back_idx_nxt  = ring_inc(back_idx_r);
                  wr_addr       = back_idx_nxt;
                  back_word_nxt = word_in;
                  if (count_r == '0) begin
                    front_word_nxt = word_in;
                  end
                end
              end
            end
            default: begin
              if (count_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                count_nxt = CNT_W'(count_r - 1'b1);
                if (in_beat.func == OP_POP_FRONT) begin
                  out_nxt.popped = to_field(front_word_r);
                  pend_pop_nxt   = front_word_r;
                  front_idx_nxt  = ring_inc(front_idx_r);
                  rd_addr        = front_idx_nxt;
                  pend_front_nxt = 1'b1;
                end else begin
                  out_nxt.popped = to_field(back_word_r);
                  pend_pop_nxt   = back_word_r;
                  back_idx_nxt   = ring_dec(back_idx_r);
                  rd_addr        = back_idx_nxt;
                  pend_front_nxt = 1'b0;
                end
                if (count_r == CNT_W'(1)) begin
                  front_word_nxt = '0;
                  back_word_nxt  = '0;
                end else begin
                  rd_en         = 1'b1;
                  out_valid_nxt = 1'b0;
                  state_nxt     = S_READ;
                end
              end
            end
          endcase
          out_nxt.front_word = to_field(front_word_nxt);
          out_nxt.back_word  = to_field(back_word_nxt);
          out_nxt.occupancy  = 7'(count_nxt);
        end
      end
      S_READ: begin
        if (pend_front_r) begin
          front_word_nxt = rd_data;
        end else begin
          back_word_nxt = rd_data;
        end
        out_nxt.popped     = to_field(pend_pop_r);
        out_nxt.status     = ST_DONE;
        out_nxt.front_word = to_field(front_word_nxt);
        out_nxt.back_word  = to_field(back_word_nxt);
        out_nxt.occupancy  = 7'(count_r);
        out_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_idx_r  <= '0;
      back_idx_r   <= IDX_LAST;
      count_r      <= '0;
      front_word_r <= '0;
      back_word_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_idx_r  <= front_idx_nxt;
      back_idx_r   <= back_idx_nxt;
      count_r      <= count_nxt;
      front_word_r <= front_word_nxt;
      back_word_r  <= back_word_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r        <= out_nxt;
    pend_pop_r   <= pend_pop_nxt;
    pend_front_r <= pend_front_nxt;
  end

  a_read_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> out_valid && state_r == S_IDLE)
    else $error("pop read did not complete into a result beat");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("fill count beyond depth");

  a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> front_word_r == '0 && back_word_r == '0)
    else $error("empty queue holds stale end words");

  a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_beat.func[1] |=> out_valid && !busy)
    else $error("push beat without a result in the next cycle");

endmodule

// ===== dv/double_ended_queue_core_test.sv =====
// double_ended_queue_core_test: self-checking bench for the double-ended queue core
// runs directed, fill-to-full and random op streams and checks every result beat
// depends on deq_pkg and double_ended_queue_core
module double_ended_queue_core_test;
  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int IX_W  = $clog2(DEPTH);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_beat = '0;
  logic busy;
  logic out_valid;
  out_t out_beat;

  logic [31:0]     ring_words [DEPTH];
  logic [IX_W-1:0] head_ix = '0;
  int unsigned     held = 0;

  out_t owed_results [$];
  int   fail_count = 0;
  int   sender_gap_pct = 0;

  double_ended_queue_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_beat (out_beat)
  );

  always #1 clk = ~clk;

  function automatic out_t deque_apply(in_t b);
    out_t r;
    r = '0;
    r.status = ST_DONE;
    if (b.func == OP_PUSH_FRONT || b.func == OP_PUSH_BACK) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else if (b.func == OP_PUSH_FRONT) begin
        head_ix = head_ix - 1'b1;
        ring_words[head_ix] = b.value;
        held++;
      end else begin
        ring_words[head_ix + IX_W'(held)] = b.value;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else if (b.func == OP_POP_FRONT) begin
        r.popped = ring_words[head_ix];
        head_ix = head_ix + 1'b1;
        held--;
      end else begin
        r.popped = ring_words[head_ix + IX_W'(held - 1)];
        held--;
      end
    end
    if (held != 0) begin
      r.front_word = ring_words[head_ix];
      r.back_word  = ring_words[head_ix + IX_W'(held - 1)];
    end
    r.occupancy = 7'(held);
    return r;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_op(input logic [1:0] op, input logic [31:0] word);
    in_t b;
    b.func  = op;
    b.value = word;
    start   <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    owed_results.push_back(deque_apply(b));
    while ($urandom_range(99) < sender_gap_pct) begin
      start         <= 1'b0;
      in_beat.func  <= 2'($urandom);
      in_beat.value <= $urandom;
      @(posedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: %p", out_beat);
      end else begin
        want = owed_results.pop_front();
        if (out_beat.popped !== want.popped || out_beat.status !== want.status ||
            out_beat.front_word !== want.front_word ||
            out_beat.back_word !== want.back_word ||
            out_beat.occupancy !== want.occupancy) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result mismatch: expected %p, got %p", want, out_beat);
        end
      end
    end
  end

  task automatic test_directed();
    issue_op(OP_POP_FRONT, 32'h1234_5678);
    issue_op(OP_POP_BACK, 32'hffff_ffff);
    issue_op(OP_PUSH_FRONT, 32'h0000_0000);
    issue_op(OP_POP_BACK, 32'h0000_0000);
    issue_op(OP_PUSH_BACK, 32'hffff_ffff);
    issue_op(OP_POP_FRONT, 32'h0000_0000);
    issue_op(OP_PUSH_FRONT, 32'haaaa_aaaa);
    issue_op(OP_PUSH_BACK, 32'h5555_5555);
    issue_op(OP_PUSH_FRONT, 32'hffff_ffff);
    issue_op(OP_PUSH_BACK, 32'h0000_0000);
    issue_op(OP_POP_FRONT, 32'hffff_ffff);
    issue_op(OP_POP_BACK, 32'h0000_0000);
    issue_op(OP_POP_FRONT, 32'h0000_0000);
    issue_op(OP_POP_BACK, 32'h0000_0000);
    issue_op(OP_POP_BACK, 32'h0000_0000);
    issue_op(OP_POP_FRONT, 32'hffff_ffff);
    issue_op(OP_PUSH_BACK, 32'h0000_0001);
    issue_op(OP_PUSH_FRONT, 32'h8000_0000);
    issue_op(OP_POP_BACK, 32'h0000_0000);
    issue_op(OP_POP_BACK, 32'h0000_0000);
  endtask

  // fill to full from both ends, bounce off full, drain to empty
  task automatic test_fill_and_drain();
    while (held < DEPTH)
      issue_op($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, random_word());
    issue_op(OP_PUSH_FRONT, random_word());
    issue_op(OP_PUSH_BACK, random_word());
    issue_op(OP_POP_FRONT, random_word());
    issue_op(OP_PUSH_BACK, random_word());
    issue_op(OP_PUSH_FRONT, random_word());
    while (held > 0)
      issue_op($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, random_word());
    issue_op(OP_POP_BACK, random_word());
  endtask

  // occupancy wanders toward a moving target level
  task automatic test_random_mix(input int n);
    int unsigned target;
    logic [1:0]  op;
    target = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0)
        target = ($urandom_range(3) == 0) ? (($urandom_range(1) ? DEPTH : 0))
                                          : $urandom_range(DEPTH);
      if ($urandom_range(9) < 2)
        op = 2'($urandom);
      else if (held < target)
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else if (held > target)
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      else
        op = 2'($urandom);
      issue_op(op, random_word());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_gap_pct = 19;
    test_directed();
    test_random_mix(75);

    sender_gap_pct = 73;
    test_fill_and_drain();
    test_random_mix(75);

    sender_gap_pct = 0;
    test_random_mix(75);
    test_fill_and_drain();

    start <= 1'b0;
    for (int w = 0; w < 200 && owed_results.size() != 0; w++) @(posedge clk);
    repeat (5) @(posedge clk);
    if (owed_results.size() != 0) begin
      fail_count++;
      $display("%0d result beats never arrived", owed_results.size());
    end

    if (fail_count == 0) begin
      $display("[double_ended_queue_core] OK");
    end else begin
      $display("[double_ended_queue_core] ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("[double_ended_queue_core] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue_core.sv
dv/double_ended_queue_core_test.sv
